[hdl/oaht_pkg.sv]
`timescale 1ns / 1ps
package oaht_pkg;
    localparam int SLOTS = 64;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int KEY_W = 34;
    localparam int CMD_W = 2;
    localparam int ST_W = 3;
    localparam int SLOT_W = 6;
    localparam int SIZE_W = 7;
    localparam int QDEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_LINEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] ST_NOFREE = 3'd2;
    localparam logic [ST_W-1:0] ST_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic             is_search;
        logic             is_quad;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] size;
    } t_job;
endpackage

[hdl/oaht_ram.sv]
`timescale 1ns / 1ps
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/oaht_front.sv]
`timescale 1ns / 1ps
module oaht_front
    import oaht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output t_job              o_job
);
    logic [SIZE_W-1:0] r_size;
    t_job              r_q [QDEPTH];
    logic [1:0]        r_cnt;
    logic              r_rd;
    logic              r_wr;
    t_job              w_job;
    logic              w_push;
    logic              w_pop;

    always_comb begin
        w_job.is_search = i_command[1];
        w_job.is_quad   = (i_command == CMD_QUAD);
        w_job.key       = i_key;
        if (r_size == '0) begin
            w_job.size = CNT_W'(1);
        end else if (r_size > SIZE_W'(SLOTS)) begin
            w_job.size = CNT_W'(SLOTS);
        end else begin
            w_job.size = CNT_W'(r_size);
        end
    end

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(SLOTS);
            r_cnt  <= '0;
            r_rd   <= 1'b0;
            r_wr   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_q[r_wr] <= w_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue count overflow");
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> (o_job.size != '0 && o_job.size <= CNT_W'(SLOTS)))
        else $error("job size out of range");
    a_full_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QDEPTH)) |-> !o_ready) else $error("ready while full");
endmodule

[hdl/oaht_back.sv]
`timescale 1ns / 1ps
module oaht_back
    import oaht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  t_job             i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ST_W-1:0]  o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic             o_table_full
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HOME = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state;
    t_job              r_job;
    logic [KEY_W-1:0]  r_rem;
    logic [5:0]        r_bit;
    logic [CNT_W-1:0]  r_i;
    logic              r_rvalid;
    logic [IDX_W-1:0]  r_ridx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [IDX_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_step;
    logic [CNT_W-1:0]  r_occ;
    logic              r_valid_q [SLOTS];
    logic              r_ovalid;
    logic [ST_W-1:0]   r_status;
    logic [SLOT_W-1:0] r_slot;
    logic              r_full;
    logic [KEY_W-1:0]  w_rdata;
    logic              w_we;
    logic [IDX_W-1:0]  w_raddr;
    logic [KEY_W:0]    w_sub;
    logic [KEY_W-1:0]  w_cand;
    logic [CNT_W:0]    w_npos;
    logic [CNT_W-1:0]  w_wrap;

    oaht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_pos),
        .i_wdata(r_job.key),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_job_ready = (r_state == S_IDLE);
    assign w_raddr     = r_i[IDX_W-1:0];
    assign w_we        = (r_state == S_DONE) && !r_ovalid && r_status == ST_INSERTED
                         && !r_job.is_search;
    assign o_valid     = r_ovalid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_table_full = r_full;

    always_comb begin
        w_cand = {r_rem[KEY_W-2:0], r_job.key[r_bit]};
        w_sub  = {1'b0, w_cand} - (KEY_W+1)'(r_job.size);
        if (r_job.is_quad) begin
            w_npos = (CNT_W+1)'(r_pos) + (CNT_W+1)'(r_step);
        end else begin
            w_npos = (CNT_W+1)'(r_pos) + (CNT_W+1)'(1);
        end
        if (w_npos >= (CNT_W+1)'(r_job.size)) begin
            w_wrap = CNT_W'(w_npos - (CNT_W+1)'(r_job.size));
        end else begin
            w_wrap = CNT_W'(w_npos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_occ    <= '0;
            r_rvalid <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_valid_q[k] <= 1'b0;
            end
        end else begin
            r_rvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_rem   <= '0;
                        r_bit   <= 6'(KEY_W - 1);
                        r_i     <= '0;
                        r_hit   <= 1'b0;
                        r_occ   <= '0;
                        r_state <= S_HOME;
                    end
                end
                S_HOME: begin
                    if (w_sub[KEY_W]) begin
                        r_rem <= w_cand;
                    end else begin
                        r_rem <= w_sub[KEY_W-1:0];
                    end
                    if (r_bit == '0) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_bit <= r_bit - 6'd1;
                    end
                end
                S_SCAN: begin
                    r_pos  <= r_rem[IDX_W-1:0];
                    r_j    <= CNT_W'(1);
                    r_step <= CNT_W'(1);
                    if (r_rvalid && r_valid_q[r_ridx]) begin
                        r_occ <= r_occ + CNT_W'(1);
                    end
                    if (r_rvalid && !r_hit && r_valid_q[r_ridx] && w_rdata == r_job.key) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_ridx;
                    end
                    if (r_i < r_job.size) begin
                        r_rvalid <= 1'b1;
                        r_ridx   <= r_i[IDX_W-1:0];
                        r_i      <= r_i + CNT_W'(1);
                    end else if (!r_rvalid) begin
                        if (r_job.is_search) begin
                            r_status <= r_hit ? ST_FOUND : ST_NOTFOUND;
                            r_slot   <= r_hit ? SLOT_W'(r_hit_idx) : '0;
                            r_state  <= S_DONE;
                        end else if (r_hit) begin
                            r_status <= ST_DUPLICATE;
                            r_slot   <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if (!r_valid_q[r_pos]) begin
                        r_status <= ST_INSERTED;
                        r_slot   <= SLOT_W'(r_pos);
                        r_state  <= S_DONE;
                    end else if (r_j >= r_job.size) begin
                        r_status <= ST_NOFREE;
                        r_slot   <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                        // In quadratic mode the step (2j-1, with j = r_j) may exceed the size, so it is
                        // reduced modulo the size as it grows.
                        if (r_step + CNT_W'(2) >= r_job.size) begin
                            r_step <= r_step + CNT_W'(2) - r_job.size;
                        end else begin
                            r_step <= r_step + CNT_W'(2);
                        end
                        r_pos <= w_wrap[IDX_W-1:0];
                    end
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        if (w_we) begin
                            r_valid_q[r_pos] <= 1'b1;
                            r_occ <= r_occ + CNT_W'(1);
                        end
                        r_ovalid <= 1'b1;
                        r_full   <= (r_occ + CNT_W'(w_we)) == r_job.size;
                    end else if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> !r_ovalid) else $error("result pending while idle");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(SLOTS)) else $error("occupancy overflow");
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !r_valid_q[r_pos]) else $error("insert over occupied slot");
endmodule

[hdl/open_addressing_hash_table_top.sv]
// A request first reduces its key modulo the table size bit by bit, then scans every
// slot within the size for the key; a search or a duplicate insert ends there, and an
// insert goes on to probe for a free slot, up to every slot of the table.
// Throughput: one request at a time in the back end; a two-entry queue in front.
// Reset (synchronous, active low) empties every slot, clears the occupancy and
// sets the table size to 64.
`timescale 1ns / 1ps
module open_addressing_hash_table_top
    import oaht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_table_full
);
    logic w_job_valid;
    logic w_job_ready;
    t_job w_job;

    oaht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_key      (i_key),
        .o_job_valid(w_job_valid),
        .i_job_ready(w_job_ready),
        .o_job      (w_job)
    );

    oaht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_table_full(o_table_full)
    );
endmodule
